/* rtl/lltsc_pkg.sv */
// ----------------------------------------------------------------------------
// lltsc_pkg
// Shared types and fixed constants of the LCD line timing and status block.
// ----------------------------------------------------------------------------
package lltsc_pkg;

  // Item operation codes; code 3 has no meaning and is ignored
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_t;

  // Display mode as kept in status bits 1..0
  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_DRAW   = 2'd3
  } mode_t;

  // Register indexes, address minus 0xFF40
  localparam logic [3:0] REG_LCDC = 4'd0;
  localparam logic [3:0] REG_STAT = 4'd1;
  localparam logic [3:0] REG_SCY  = 4'd2;
  localparam logic [3:0] REG_SCX  = 4'd3;
  localparam logic [3:0] REG_LY   = 4'd4;
  localparam logic [3:0] REG_LYC  = 4'd5;
  localparam logic [3:0] REG_BGP  = 4'd7;
  localparam logic [3:0] REG_OBP0 = 4'd8;
  localparam logic [3:0] REG_OBP1 = 4'd9;

  // Dot positions where the mode switches inside a visible line
  localparam logic [10:0] DRAW_START   = 11'd80;
  localparam logic [10:0] HBLANK_START = 11'd252;

  localparam logic [7:0] STAT_WR_MASK  = 8'hF8;
  localparam logic [7:0] UNMAPPED_DATA = 8'hFF;

  // Bit positions in control and status
  localparam int LCDC_ENABLE_BIT = 7;
  localparam int STAT_MATCH_BIT  = 2;
  localparam int STAT_HBLANK_IE  = 3;
  localparam int STAT_VBLANK_IE  = 4;
  localparam int STAT_OAM_IE     = 5;
  localparam int STAT_MATCH_IE   = 6;

  // Reset values
  localparam logic [7:0] LCDC_RESET = 8'h91;
  localparam logic [7:0] STAT_RESET = 8'h85;
  localparam logic [7:0] BGP_RESET  = 8'hFC;
  localparam logic [7:0] OBP_RESET  = 8'hFF;

endpackage

/* rtl/lltsc_if.sv */
// ----------------------------------------------------------------------------
// lltsc_if
// Valid/ready channels of the LCD line timing block: item in, result out.
// ----------------------------------------------------------------------------
interface lltsc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] elapsed_dots;
  logic [3:0] register_index;
  logic [7:0] write_data;

  modport source (output valid, output operation, output elapsed_dots,
                  output register_index, output write_data, input ready);
  modport sink   (input valid, input operation, input elapsed_dots,
                  input register_index, input write_data, output ready);
endinterface

interface lltsc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       vblank_request;
  logic       status_request;

  modport source (output valid, output read_data, output vblank_request,
                  output status_request, input ready);
  modport sink   (input valid, input read_data, input vblank_request,
                  input status_request, output ready);
endinterface

/* rtl/lcd_line_timing_stat_controller_core.sv */
// ----------------------------------------------------------------------------
// lcd_line_timing_stat_controller_core
// Dot counter, line counter, mode and interrupt requests of an LCD video unit.
// ----------------------------------------------------------------------------
// Each input beat is a tick (advance by elapsed_dots), a register read or a
// register write at 0xFF40 plus register_index; each yields exactly one result
// beat. The block takes one beat per cycle while in_ch.ready is high: the state
// update is a single add-and-compare on the dot counter and line, done in the
// cycle the beat is accepted, and the result lands in one output register in the
// cycle after. That output register is the only buffer, so in_ch.ready drops
// only while a result waits and out_ch.ready is low; with the sink ready,
// throughput is one beat per cycle.
// ----------------------------------------------------------------------------
module lcd_line_timing_stat_controller_core
  import lltsc_pkg::*;
#(
  parameter int VISIBLE_LINES = 144,
  parameter int BLANK_LINES   = 10,
  parameter int DOTS_PER_LINE = 456
) (
  input  logic        clk,
  input  logic        rst_n,
  lltsc_in_if.sink    in_ch,
  lltsc_out_if.source out_ch
);

  localparam logic [7:0]  VIS_LINE  = 8'(VISIBLE_LINES);
  localparam logic [7:0]  WRAP_LINE = 8'(VISIBLE_LINES + BLANK_LINES);
  localparam logic [10:0] LINE_DOTS = 11'(DOTS_PER_LINE);

  // Timing and register state
  logic [9:0] dot_r,  dot_nxt;
  logic [7:0] line_r, line_nxt;
  logic [7:0] lcdc_r, lcdc_nxt;
  logic [7:0] stat_r, stat_nxt;
  logic [7:0] lyc_r,  lyc_nxt;
  logic [7:0] scy_r,  scy_nxt;
  logic [7:0] scx_r,  scx_nxt;
  logic [7:0] bgp_r,  bgp_nxt;
  logic [7:0] obp0_r, obp0_nxt;
  logic [7:0] obp1_r, obp1_nxt;

  // Result register
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_data_r,  rd_nxt;
  logic       out_vb_r,    vb_nxt;
  logic       out_st_r,    st_nxt;

  logic       in_fire;
  logic [10:0] dot_sum;
  logic [10:0] dot_wrap;
  logic [7:0]  line_inc;
  mode_t       mode_new;

  // Accept while the result slot is empty or being drained this cycle
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.read_data      = out_data_r;
  assign out_ch.vblank_request = out_vb_r;
  assign out_ch.status_request = out_st_r;

  // Dot sum and the mode it implies for the current line
  assign dot_sum  = {1'b0, dot_r} + {3'b000, in_ch.elapsed_dots};
  assign dot_wrap = dot_sum - LINE_DOTS;
  assign line_inc = line_r + 8'd1;

  always_comb begin
    if (line_r >= VIS_LINE) begin
      mode_new = MODE_VBLANK;
    end else if (dot_sum >= HBLANK_START) begin
      mode_new = MODE_HBLANK;
    end else if (dot_sum >= DRAW_START) begin
      mode_new = MODE_DRAW;
    end else begin
      mode_new = MODE_OAM;
    end
  end

  always_comb begin
    dot_nxt  = dot_r;
    line_nxt = line_r;
    lcdc_nxt = lcdc_r;
    stat_nxt = stat_r;
    lyc_nxt  = lyc_r;
    scy_nxt  = scy_r;
    scx_nxt  = scx_r;
    bgp_nxt  = bgp_r;
    obp0_nxt = obp0_r;
    obp1_nxt = obp1_r;
    rd_nxt   = 8'h00;
    vb_nxt   = 1'b0;
    st_nxt   = 1'b0;

    case (in_ch.operation)
      OP_TICK: begin
        if (!lcdc_r[LCDC_ENABLE_BIT]) begin
          // Display off: park at line 0, dot 0, mode 0; match bit untouched
          dot_nxt       = '0;
          line_nxt      = '0;
          stat_nxt[1:0] = MODE_HBLANK;
        end else begin
          // Mode change, with its interrupt enable
          if (stat_r[1:0] != mode_new) begin
            stat_nxt[1:0] = mode_new;
            case (mode_new)
              MODE_HBLANK: st_nxt = stat_r[STAT_HBLANK_IE];
              MODE_VBLANK: st_nxt = stat_r[STAT_VBLANK_IE];
              MODE_OAM:    st_nxt = stat_r[STAT_OAM_IE];
              default:     st_nxt = 1'b0;
            endcase
          end
          // Line compare: raise only on a rising match
          if (line_r == lyc_r) begin
            stat_nxt[STAT_MATCH_BIT] = 1'b1;
            if (!stat_r[STAT_MATCH_BIT] && stat_r[STAT_MATCH_IE]) begin
              st_nxt = 1'b1;
            end
          end else begin
            stat_nxt[STAT_MATCH_BIT] = 1'b0;
          end
          // End of line: advance, flag vertical blank, wrap the frame
          if (dot_sum >= LINE_DOTS) begin
            dot_nxt = dot_wrap[9:0];
            if (line_inc == VIS_LINE) begin
              line_nxt = line_inc;
              vb_nxt   = 1'b1;
            end else if (line_inc >= WRAP_LINE) begin
              line_nxt = '0;
            end else begin
              line_nxt = line_inc;
            end
          end else begin
            dot_nxt = dot_sum[9:0];
          end
        end
      end
      OP_READ: begin
        case (in_ch.register_index)
          REG_LCDC: rd_nxt = lcdc_r;
          REG_STAT: rd_nxt = stat_r;
          REG_SCY:  rd_nxt = scy_r;
          REG_SCX:  rd_nxt = scx_r;
          REG_LY:   rd_nxt = line_r;
          REG_LYC:  rd_nxt = lyc_r;
          REG_BGP:  rd_nxt = bgp_r;
          REG_OBP0: rd_nxt = obp0_r;
          REG_OBP1: rd_nxt = obp1_r;
          default:  rd_nxt = UNMAPPED_DATA;
        endcase
      end
      OP_WRITE: begin
        case (in_ch.register_index)
          REG_LCDC: lcdc_nxt = in_ch.write_data;
          // Keep mode and match bits, take the enables
          REG_STAT: stat_nxt = (in_ch.write_data & STAT_WR_MASK) |
                               (stat_r & ~STAT_WR_MASK);
          REG_SCY:  scy_nxt  = in_ch.write_data;
          REG_SCX:  scx_nxt  = in_ch.write_data;
          REG_LYC:  lyc_nxt  = in_ch.write_data;
          REG_BGP:  bgp_nxt  = in_ch.write_data;
          REG_OBP0: obp0_nxt = in_ch.write_data;
          REG_OBP1: obp1_nxt = in_ch.write_data;
          default: ; // line register and unmapped: drop the write
        endcase
      end
      default: ; // unknown operation: no change, zero result
    endcase
  end

  // Hold the result while stalled, reload on every accepted beat
  assign out_valid_nxt = in_fire || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r       <= '0;
      line_r      <= '0;
      lcdc_r      <= LCDC_RESET;
      stat_r      <= STAT_RESET;
      lyc_r       <= '0;
      scy_r       <= '0;
      scx_r       <= '0;
      bgp_r       <= BGP_RESET;
      obp0_r      <= OBP_RESET;
      obp1_r      <= OBP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        dot_r  <= dot_nxt;
        line_r <= line_nxt;
        lcdc_r <= lcdc_nxt;
        stat_r <= stat_nxt;
        lyc_r  <= lyc_nxt;
        scy_r  <= scy_nxt;
        scx_r  <= scx_nxt;
        bgp_r  <= bgp_nxt;
        obp0_r <= obp0_nxt;
        obp1_r <= obp1_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= rd_nxt;
      out_vb_r   <= vb_nxt;
      out_st_r   <= st_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_line_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    line_r < WRAP_LINE)
    else $error("line counter left the frame");

  a_disabled_tick_parks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.operation == OP_TICK && !lcdc_r[LCDC_ENABLE_BIT]) |=>
      (line_r == 8'd0 && dot_r == 10'd0 && stat_r[1:0] == MODE_HBLANK))
    else $error("disabled tick did not park the timing");

  a_vblank_on_entry: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (!out_vb_r || line_r == VIS_LINE))
    else $error("vertical blank request off its line");

  a_read_data_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.operation != OP_READ) |=> (out_data_r == 8'h00))
    else $error("read data on a non-read beat");

  a_requests_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.operation != OP_TICK) |=> (!out_vb_r && !out_st_r))
    else $error("interrupt request on a non-tick beat");
`endif

endmodule
